// ===== sv/bgr_pkg.sv =====
// Shared constants and types of the bilinear grey resizer.
package bgr_pkg;

  // Fixed point format of positions and weights.
  localparam int unsigned FRAC_W       = 14;
  localparam int unsigned Q_ONE        = 16384;
  localparam int unsigned Q_HALF       = 8192;
  localparam int unsigned EDGE_BACKOFF = 164;

  // Default frame store geometry.
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  // Field widths of the request and result items.
  localparam int unsigned OPCODE_W    = 1;
  localparam int unsigned SRC_COORD_W = 10;
  localparam int unsigned PIXEL_W     = 8;
  localparam int unsigned DST_COORD_W = 12;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 8;

  // Configuration register widths.
  localparam int unsigned SIZE_REG_W = 11;
  localparam int unsigned STEP_W     = 25;
  localparam int unsigned CFG_DATA_W = 25;
  localparam int unsigned CFG_IDX_W  = 2;

  // Datapath widths.
  localparam int unsigned POS_RAW_W = DST_COORD_W + STEP_W;
  localparam int unsigned WEIGHT_W  = FRAC_W + 1;
  localparam int unsigned BLEND_W   = WEIGHT_W + PIXEL_W;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD    = 1'b0,
    OP_COMPUTE = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_STEP_X     = 2'd2,
    REG_STEP_Y     = 2'd3
  } cfg_reg_e;

endpackage

// ===== sv/bgr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bgr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bilinear_gray_resizer_unit.sv =====
// Top level of the bilinear grey resizer: frame store, Q14 position pipeline and blending.
//
// The unit keeps an 8-bit grey source frame and produces bilinearly interpolated
// destination pixels from it. A request with opcode load writes one source pixel
// (writes outside MAX_WIDTH x MAX_HEIGHT are dropped and give no result); a request with
// opcode compute names a destination pixel and gives exactly one result byte. Source
// positions are coordinate times the Q14 step registers; a position that reaches the
// last column or row is pulled back to just below it, so all four neighbours always lie
// inside the frame. The frame store is split into four banks by row and column parity,
// so the four neighbours of any position come from four different banks in one cycle.
// The unit accepts one request per clock while s_axis_tready is high, loads and computes
// mixed freely, in a five-stage pipeline: position multiply, clamp and bank addressing,
// bank access, two horizontal blends, vertical blend into the output register. A compute
// passes the stage A, B, C, D and E registers in order before m_axis_tvalid rises.
// Stalls on the output side back up stage by stage, so the pipeline keeps accepting
// requests until every stage is full. Loads write the store at the bank access stage,
// in request order, so a compute always sees exactly the loads accepted before it. The
// store has no reset and needs no clearing pass; a pixel must be loaded before any
// compute reads it. Configuration registers are written through the cfg port, which is
// always ready; the user must write them only while the pipeline is empty, and the unit
// does not enforce this.
module bilinear_gray_resizer_unit
  import bgr_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Request stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [9:0] src_col, [19:10] src_row, [27:20] src_pixel, [39:28] dst_col,
  // [51:40] dst_row, [55:52] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] opcode
  input  logic [OPCODE_W-1:0]    s_axis_tuser,
  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] out_pixel
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // Configuration write channel.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  // Geometry derived from the frame size.
  localparam int unsigned XW     = $clog2(MAX_WIDTH);
  localparam int unsigned YW     = $clog2(MAX_HEIGHT);
  localparam int unsigned HALF_W = (MAX_WIDTH + 1) / 2;
  localparam int unsigned HALF_H = (MAX_HEIGHT + 1) / 2;
  localparam int unsigned CB     = (HALF_W > 1) ? $clog2(HALF_W) : 1;
  localparam int unsigned RB     = (HALF_H > 1) ? $clog2(HALF_H) : 1;
  localparam int unsigned BANK_DEPTH = HALF_H * (1 << CB);
  localparam int unsigned BAW    = $clog2(BANK_DEPTH);
  localparam int unsigned LXW    = XW + FRAC_W;
  localparam int unsigned LYW    = YW + FRAC_W;
  localparam int unsigned SWX    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SWY    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned SWM    = (SWX > SWY) ? SWX : SWY;
  localparam int unsigned CW     = (SWM > SIZE_REG_W) ? SWM : SIZE_REG_W;

  // Rounded Q14 blend of two pixels, the first one weighted by w.
  function automatic logic [PIXEL_W-1:0] blend(input logic [WEIGHT_W-1:0] w,
                                               input logic [PIXEL_W-1:0]  a,
                                               input logic [PIXEL_W-1:0]  b);
    logic [BLEND_W-1:0] s;
    s = BLEND_W'(w) * BLEND_W'(a)
      + BLEND_W'(WEIGHT_W'(Q_ONE) - w) * BLEND_W'(b)
      + BLEND_W'(Q_HALF);
    return s[FRAC_W+PIXEL_W-1:FRAC_W];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration. Sizes are stored clamped and minus one, since only the last
  // valid column and row are ever needed.
  // ---------------------------------------------------------------------------
  logic [XW-1:0]     wm1_q, wm1_d;
  logic [YW-1:0]     hm1_q, hm1_d;
  logic [STEP_W-1:0] step_x_q, step_x_d;
  logic [STEP_W-1:0] step_y_q, step_y_d;
  logic [CW-1:0]     cfg_size;
  logic [CW-1:0]     size_w_sat;
  logic [CW-1:0]     size_h_sat;

  assign cfg_ready_o = 1'b1;
  assign cfg_size    = CW'(cfg_data_i[SIZE_REG_W-1:0]);

  always_comb begin
    if (cfg_size < CW'(2)) begin
      size_w_sat = CW'(2);
    end else if (cfg_size > CW'(MAX_WIDTH)) begin
      size_w_sat = CW'(MAX_WIDTH);
    end else begin
      size_w_sat = cfg_size;
    end
    if (cfg_size < CW'(2)) begin
      size_h_sat = CW'(2);
    end else if (cfg_size > CW'(MAX_HEIGHT)) begin
      size_h_sat = CW'(MAX_HEIGHT);
    end else begin
      size_h_sat = cfg_size;
    end
  end

  always_comb begin
    wm1_d    = wm1_q;
    hm1_d    = hm1_q;
    step_x_d = step_x_q;
    step_y_d = step_y_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SRC_WIDTH:  wm1_d    = XW'(size_w_sat - CW'(1));
        REG_SRC_HEIGHT: hm1_d    = YW'(size_h_sat - CW'(1));
        REG_STEP_X:     step_x_d = cfg_data_i[STEP_W-1:0];
        REG_STEP_Y:     step_y_d = cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm1_q    <= XW'(1);
      hm1_q    <= YW'(1);
      step_x_q <= STEP_W'(Q_ONE);
      step_y_q <= STEP_W'(Q_ONE);
    end else begin
      wm1_q    <= wm1_d;
      hm1_q    <= hm1_d;
      step_x_q <= step_x_d;
      step_y_q <= step_y_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. Each stage moves when it is empty or when the stage
  // after it moves, so bubbles collapse and a stall loses nothing.
  // ---------------------------------------------------------------------------
  logic v_a_q, v_b_q, v_c_q, v_d_q, v_e_q;
  logic en_a, en_b, en_c, en_d, en_e;

  assign en_e = !v_e_q || m_axis_tready;
  assign en_d = !v_d_q || en_e;
  assign en_c = !v_c_q || en_d;
  assign en_b = !v_b_q || en_c;
  assign en_a = !v_a_q || en_b;

  assign s_axis_tready = en_a;

  // Request fields.
  logic [SRC_COORD_W-1:0] in_src_col;
  logic [SRC_COORD_W-1:0] in_src_row;
  logic [PIXEL_W-1:0]     in_src_pixel;
  logic [DST_COORD_W-1:0] in_dst_col;
  logic [DST_COORD_W-1:0] in_dst_row;

  assign in_src_col   = s_axis_tdata[9:0];
  assign in_src_row   = s_axis_tdata[19:10];
  assign in_src_pixel = s_axis_tdata[27:20];
  assign in_dst_col   = s_axis_tdata[39:28];
  assign in_dst_row   = s_axis_tdata[51:40];

  // ---------------------------------------------------------------------------
  // Stage A: raw Q14 positions, coordinate times step.
  // ---------------------------------------------------------------------------
  opcode_e                op_a_q;
  logic [POS_RAW_W-1:0]   px_a_q, py_a_q;
  logic [SRC_COORD_W-1:0] ld_col_a_q, ld_row_a_q;
  logic [PIXEL_W-1:0]     ld_pix_a_q;

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      op_a_q     <= opcode_e'(s_axis_tuser);
      px_a_q     <= POS_RAW_W'(in_dst_col) * POS_RAW_W'(step_x_q);
      py_a_q     <= POS_RAW_W'(in_dst_row) * POS_RAW_W'(step_y_q);
      ld_col_a_q <= in_src_col;
      ld_row_a_q <= in_src_row;
      ld_pix_a_q <= in_src_pixel;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: edge clamp, neighbour weights and per-bank addresses. Bank index is
  // {row parity, column parity}; the neighbour of a bank is the top-left pixel's
  // row or column when the parity matches, and the next one otherwise.
  // ---------------------------------------------------------------------------
  logic [LXW-1:0]  lim_x, pos_x;
  logic [LYW-1:0]  lim_y, pos_y;
  logic [XW-1:0]   x0;
  logic [YW-1:0]   y0;
  logic [BAW-1:0]  raddr_d [4];
  logic            ld_ok;
  logic [BAW-1:0]  ld_addr;

  assign lim_x = {wm1_q, FRAC_W'(0)};
  assign lim_y = {hm1_q, FRAC_W'(0)};

  always_comb begin
    if (px_a_q >= POS_RAW_W'(lim_x)) begin
      pos_x = lim_x - LXW'(EDGE_BACKOFF);
    end else begin
      pos_x = px_a_q[LXW-1:0];
    end
    if (py_a_q >= POS_RAW_W'(lim_y)) begin
      pos_y = lim_y - LYW'(EDGE_BACKOFF);
    end else begin
      pos_y = py_a_q[LYW-1:0];
    end
  end

  assign x0 = pos_x[LXW-1:FRAC_W];
  assign y0 = pos_y[LYW-1:FRAC_W];

  always_comb begin
    logic [CB:0]   x0_ext;
    logic [RB:0]   y0_ext;
    logic [CB-1:0] col_half;
    logic [RB-1:0] row_half;
    logic [1:0]    kb;
    x0_ext = (CB + 1)'(x0);
    y0_ext = (RB + 1)'(y0);
    for (int k = 0; k < 4; k++) begin
      kb          = 2'(k);
      col_half    = x0_ext[CB:1] + CB'(x0_ext[0] & ~kb[0]);
      row_half    = y0_ext[RB:1] + RB'(y0_ext[0] & ~kb[1]);
      raddr_d[k]  = BAW'({row_half, col_half});
    end
  end

  assign ld_ok   = (32'(ld_col_a_q) < 32'(MAX_WIDTH)) && (32'(ld_row_a_q) < 32'(MAX_HEIGHT));
  assign ld_addr = BAW'({RB'(ld_row_a_q[SRC_COORD_W-1:1]), CB'(ld_col_a_q[SRC_COORD_W-1:1])});

  opcode_e             op_b_q;
  logic [WEIGHT_W-1:0] wx_b_q, wy_b_q;
  logic                xp_b_q, yp_b_q;
  logic [BAW-1:0]      raddr_b_q [4];
  logic                ld_ok_b_q;
  logic [BAW-1:0]      ld_addr_b_q;
  logic [1:0]          ld_bank_b_q;
  logic [PIXEL_W-1:0]  ld_pix_b_q;

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      op_b_q      <= op_a_q;
      wx_b_q      <= WEIGHT_W'(Q_ONE) - WEIGHT_W'(pos_x[FRAC_W-1:0]);
      wy_b_q      <= WEIGHT_W'(Q_ONE) - WEIGHT_W'(pos_y[FRAC_W-1:0]);
      xp_b_q      <= x0[0];
      yp_b_q      <= y0[0];
      raddr_b_q   <= raddr_d;
      ld_ok_b_q   <= ld_ok;
      ld_addr_b_q <= ld_addr;
      ld_bank_b_q <= {ld_row_a_q[0], ld_col_a_q[0]};
      ld_pix_b_q  <= ld_pix_a_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: frame store banks. A load writes here and leaves the pipeline; a
  // compute reads one pixel from every bank.
  // ---------------------------------------------------------------------------
  logic [3:0]         bank_we;
  logic [PIXEL_W-1:0] bank_rdata [4];

  for (genvar g = 0; g < 4; g++) begin : g_bank
    assign bank_we[g] = en_c && v_b_q && (op_b_q == OP_LOAD) && ld_ok_b_q
                        && (ld_bank_b_q == 2'(g));
    bgr_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we[g]),
      .waddr_i (ld_addr_b_q),
      .wdata_i (ld_pix_b_q),
      .re_i    (en_c),
      .raddr_i (raddr_b_q[g]),
      .rdata_o (bank_rdata[g])
    );
  end

  logic [WEIGHT_W-1:0] wx_c_q, wy_c_q;
  logic                xp_c_q, yp_c_q;

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      wx_c_q <= wx_b_q;
      wy_c_q <= wy_b_q;
      xp_c_q <= xp_b_q;
      yp_c_q <= yp_b_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: horizontal blends of the top and bottom neighbour pairs.
  // ---------------------------------------------------------------------------
  logic [PIXEL_W-1:0]  top_d_q, bot_d_q;
  logic [WEIGHT_W-1:0] wy_d_q;

  always_ff @(posedge clk_i) begin
    if (en_d) begin
      top_d_q <= blend(wx_c_q, bank_rdata[{yp_c_q, xp_c_q}],
                       bank_rdata[{yp_c_q, ~xp_c_q}]);
      bot_d_q <= blend(wx_c_q, bank_rdata[{~yp_c_q, xp_c_q}],
                       bank_rdata[{~yp_c_q, ~xp_c_q}]);
      wy_d_q  <= wy_c_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage E: vertical blend into the output register.
  // ---------------------------------------------------------------------------
  logic [PIXEL_W-1:0] out_pixel_q;

  always_ff @(posedge clk_i) begin
    if (en_e) begin
      out_pixel_q <= blend(wy_d_q, top_d_q, bot_d_q);
    end
  end

  assign m_axis_tvalid = v_e_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_pixel_q);

  // Valid bits. Loads are dropped after the bank stage since they give no result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
      v_d_q <= 1'b0;
      v_e_q <= 1'b0;
    end else begin
      if (en_a) begin
        v_a_q <= s_axis_tvalid;
      end
      if (en_b) begin
        v_b_q <= v_a_q;
      end
      if (en_c) begin
        v_c_q <= v_b_q && (op_b_q == OP_COMPUTE);
      end
      if (en_d) begin
        v_d_q <= v_c_q;
      end
      if (en_e) begin
        v_e_q <= v_d_q;
      end
    end
  end

`ifndef SYNTHESIS
  // Back-pressure reaches the request side only when every stage holds an item.
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v_a_q && v_b_q && v_c_q && v_d_q && v_e_q))
    else $error("request side stalled while a pipeline stage is empty");

  // A load writes at most one bank.
  a_single_bank_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(bank_we))
    else $error("more than one frame store bank written in one cycle");

  // Q_ONE minus a 14-bit fraction keeps the top-left weight in 1..16384.
  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_b_q && (op_b_q == OP_COMPUTE)) |->
      (wx_b_q != '0 && wx_b_q <= WEIGHT_W'(Q_ONE) &&
       wy_b_q != '0 && wy_b_q <= WEIGHT_W'(Q_ONE)))
    else $error("neighbour weight out of range");

  // A compute that passes the bank stage arrives at the blend stage.
  a_compute_reaches_blend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_c && v_b_q && (op_b_q == OP_COMPUTE)) |=> v_c_q)
    else $error("compute request lost at the frame store stage");
`endif

endmodule
